// ===== design/dget_pkg.sv =====
// ----------------------------------------------------------------------------
// dget_pkg: shared types and constants for the directed graph edge table
// request codes, field widths and default sizing
// ----------------------------------------------------------------------------
package dget_pkg;

  localparam int DEF_MAX_NODES = 16;
  localparam int DEF_KEY_WIDTH = 32;
  localparam int REQ_W         = 3;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD_NODE = 3'd0,
    REQ_DEL_NODE = 3'd1,
    REQ_ADD_EDGE = 3'd2,
    REQ_DEL_EDGE = 3'd3,
    REQ_HAS_NODE = 3'd4,
    REQ_HAS_EDGE = 3'd5
  } req_t;

endpackage

// ===== design/directed_graph_edge_table.sv =====
// an accepted item waits in the input register; its result goes into the result register once that can take it
// throughput: one item per cycle while the result side is not stalled; one registered pass holds lookup and update
// the slot compare and the row and column clears all sit between the two registers
// reset (rst, synchronous): all slots free, matrix cleared, both stages empty
// ----------------------------------------------------------------------------
// directed_graph_edge_table: directed graph held as an adjacency bit matrix
// key-addressed slot table maps node keys to slots; rows of the matrix hold
// out-edges, columns in-edges; each item adds, removes or queries a node/edge
// ----------------------------------------------------------------------------
module directed_graph_edge_table
  import dget_pkg::*;
#(
  parameter int MAX_NODES = DEF_MAX_NODES,
  parameter int KEY_WIDTH = DEF_KEY_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst,
  // request channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [REQ_W-1:0]            req_type,
  input  logic signed [KEY_WIDTH-1:0] key_a,
  input  logic signed [KEY_WIDTH-1:0] key_b,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        success,
  output logic                        table_full
);

  typedef logic [MAX_NODES-1:0] vec_t;

  // input register
  logic                 ir_valid;
  logic [REQ_W-1:0]     ir_type;
  logic [KEY_WIDTH-1:0] ir_key_a;
  logic [KEY_WIDTH-1:0] ir_key_b;

  // graph state: slot table (key store has no reset, guarded by slot_used)
  vec_t                 slot_used;
  logic [KEY_WIDTH-1:0] slot_key [MAX_NODES];
  vec_t                 edge_row [MAX_NODES];

  vec_t                 slot_used_next;
  vec_t                 edge_row_next [MAX_NODES];
  vec_t                 key_write;

  vec_t                 hit_a;     // one-hot slot of key_a, zero if absent
  vec_t                 hit_b;     // one-hot slot of key_b, zero if absent
  vec_t                 free_vec;
  vec_t                 free_oh;   // lowest free slot
  logic                 found_a;
  logic                 found_b;
  logic                 edge_set;
  logic                 fire;
  logic                 success_next;
  logic                 table_full_next;

  // the item in the input register is processed when the result register can take it
  assign fire     = ir_valid && (!out_valid || !out_stall);
  assign in_stall = ir_valid && !fire;

  // parallel key compare over every slot
  always_comb begin
    for (int i = 0; i < MAX_NODES; i++) begin
      hit_a[i] = slot_used[i] && (slot_key[i] == ir_key_a);
      hit_b[i] = slot_used[i] && (slot_key[i] == ir_key_b);
    end
  end

  assign found_a  = |hit_a;
  assign found_b  = |hit_b;
  assign free_vec = ~slot_used;
  assign free_oh  = free_vec & (~free_vec + vec_t'(1));

  // edge bit of the selected row and column
  always_comb begin
    edge_set = 1'b0;
    for (int i = 0; i < MAX_NODES; i++) begin
      edge_set = edge_set | (hit_a[i] && |(edge_row[i] & hit_b));
    end
  end

  // next state and result for one request
  always_comb begin
    slot_used_next  = slot_used;
    key_write       = '0;
    success_next    = 1'b0;
    table_full_next = 1'b0;
    for (int i = 0; i < MAX_NODES; i++) begin
      edge_row_next[i] = edge_row[i];
    end
    case (ir_type)
      REQ_ADD_NODE: begin
        if (!found_a) begin
          if (slot_used == '1) begin
            table_full_next = 1'b1;
          end else begin
            // a freed slot already has its row and column clear
            slot_used_next = slot_used | free_oh;
            key_write      = free_oh;
            success_next   = 1'b1;
          end
        end
      end
      REQ_DEL_NODE: begin
        if (found_a) begin
          slot_used_next = slot_used & ~hit_a;
          for (int i = 0; i < MAX_NODES; i++) begin
            // clear its column everywhere and its whole row
            edge_row_next[i] = hit_a[i] ? '0 : (edge_row[i] & ~hit_a);
          end
          success_next = 1'b1;
        end
      end
      REQ_ADD_EDGE: begin
        if (found_a && found_b) begin
          for (int i = 0; i < MAX_NODES; i++) begin
            if (hit_a[i]) begin
              edge_row_next[i] = edge_row[i] | hit_b;
            end
          end
          success_next = 1'b1;
        end
      end
      REQ_DEL_EDGE: begin
        if (edge_set) begin
          for (int i = 0; i < MAX_NODES; i++) begin
            if (hit_a[i]) begin
              edge_row_next[i] = edge_row[i] & ~hit_b;
            end
          end
          success_next = 1'b1;
        end
      end
      REQ_HAS_NODE: begin
        success_next = found_a;
      end
      REQ_HAS_EDGE: begin
        success_next = edge_set;
      end
      default: begin
        // unused codes answer nothing found and change nothing
        success_next = 1'b0;
      end
    endcase
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      ir_valid <= 1'b1;
    end else if (fire) begin
      ir_valid <= 1'b0;
    end
    if (in_valid && !in_stall) begin
      ir_type  <= req_type;
      ir_key_a <= key_a;
      ir_key_b <= key_b;
    end
  end

  // graph state
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_used <= '0;
      for (int i = 0; i < MAX_NODES; i++) begin
        edge_row[i] <= '0;
      end
    end else if (fire) begin
      slot_used <= slot_used_next;
      for (int i = 0; i < MAX_NODES; i++) begin
        edge_row[i] <= edge_row_next[i];
      end
    end
  end

  // key store, written only when a slot is taken
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_NODES; i++) begin
      if (fire && key_write[i]) begin
        slot_key[i] <= ir_key_a;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (fire) begin
      success    <= success_next;
      table_full <= table_full_next;
    end
  end

endmodule

// ===== design/dget_checker.sv =====
// ----------------------------------------------------------------------------
// dget_checker: port-level checks for the directed graph edge table
// watches both handshakes and the result flags
// ----------------------------------------------------------------------------
module dget_checker
  import dget_pkg::*;
#(
  parameter int KEY_WIDTH = DEF_KEY_WIDTH
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic [REQ_W-1:0]            req_type,
  input logic signed [KEY_WIDTH-1:0] key_a,
  input logic signed [KEY_WIDTH-1:0] key_b,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic                        success,
  input logic                        table_full
);

  // a held request keeps its value
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(req_type) && $stable(key_a) &&
    $stable(key_b))
    else $error("request changed while stalled");

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(success) && $stable(table_full))
    else $error("result changed while stalled");

  // a full table never reports success
  a_full_fail: assert property (@(posedge clk) disable iff (rst)
    out_valid && table_full |-> !success)
    else $error("table_full with success");

  // requests are only held back when the result side is blocked
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    (!out_valid || !out_stall) |-> !in_stall)
    else $error("request stalled while result side free");

  // reset empties the result stage
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind directed_graph_edge_table dget_checker #(.KEY_WIDTH(KEY_WIDTH)) u_dget_checker (.*);
